// ----- sv/sdz_pkg.sv -----
// Shared constants for the stick dead-zone shaper.
package sdz_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS = 15;
  localparam int OUT_BITS = FRAC_BITS + 2;
  localparam int REG_BITS = 15;
  localparam int IN_BITS = 2 * SAMPLE_BITS;
  localparam int OUT_DATA_BITS = 40;
  localparam int SQ_BITS = 32;
  localparam int ROOT_BITS = 16;
  localparam int NUM_BITS = 31;
  localparam int DEN_BITS = 16;
  localparam int Q_BITS = 16;
  localparam int SQRT_LAT = ROOT_BITS;
  localparam int DIV_LAT = Q_BITS + 2;

  localparam logic [Q_BITS-1:0] ONE_Q = 16'h8000;

  localparam logic [1:0] MODE_INDEP = 2'd0;
  localparam logic [1:0] MODE_CIRC = 2'd1;
  localparam logic [1:0] MODE_NONE = 2'd2;

  localparam logic [1:0] REG_ZONE_MODE = 2'd0;
  localparam logic [1:0] REG_DEAD_ZONE = 2'd1;
  localparam logic [1:0] REG_FULL_SCALE = 2'd2;

  localparam logic [REG_BITS-1:0] RST_DEAD_ZONE = 15'd7849;
  localparam logic [REG_BITS-1:0] RST_FULL_SCALE = 15'd32767;
endpackage

// ----- sv/sdz_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module sdz_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sdz_pkg::SQ_BITS-1:0]   n,
  output logic [sdz_pkg::ROOT_BITS-1:0] root
);
  import sdz_pkg::*;

  logic [ROOT_BITS+1:0] rem   [SQRT_LAT];
  logic [ROOT_BITS-1:0] rt    [SQRT_LAT];
  logic [SQ_BITS-1:0]   nn    [SQRT_LAT];
  logic [ROOT_BITS+1:0] rem_n [SQRT_LAT];
  logic [ROOT_BITS-1:0] rt_n  [SQRT_LAT];
  logic [SQ_BITS-1:0]   nn_n  [SQRT_LAT];

  always_comb begin
    logic [ROOT_BITS+1:0] rp;
    logic [ROOT_BITS-1:0] tp;
    logic [SQ_BITS-1:0]   np;
    logic [ROOT_BITS+3:0] r4;
    logic [ROOT_BITS+3:0] trial;
    logic                 ge;
    for (int k = 0; k < SQRT_LAT; k++) begin
      rp = (k == 0) ? '0 : rem[(k == 0) ? 0 : k - 1];
      tp = (k == 0) ? '0 : rt[(k == 0) ? 0 : k - 1];
      np = (k == 0) ? n : nn[(k == 0) ? 0 : k - 1];
      r4 = {rp, np[SQ_BITS-1:SQ_BITS-2]};
      trial = {2'b00, tp, 2'b01};
      ge = (r4 >= trial);
      rem_n[k] = ge ? 18'(r4 - trial) : r4[ROOT_BITS+1:0];
      rt_n[k] = {tp[ROOT_BITS-2:0], ge};
      nn_n[k] = {np[SQ_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        rem[k] <= rem_n[k];
        rt[k] <= rt_n[k];
        nn[k] <= nn_n[k];
      end
    end
  end

  assign root = rt[SQRT_LAT-1];
endmodule

// ----- sv/sdz_div.sv -----
// Pipelined saturating divider, one quotient bit per stage, result clamped to 1.0.
module sdz_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sdz_pkg::NUM_BITS-1:0] num,
  input  logic [sdz_pkg::DEN_BITS-1:0] den,
  output logic [sdz_pkg::Q_BITS-1:0]   quot
);
  import sdz_pkg::*;

  localparam int NS = Q_BITS + 1;

  logic [DEN_BITS-1:0] rem [NS];
  logic [Q_BITS-1:0]   low [NS];
  logic [Q_BITS-1:0]   q   [NS];
  logic [DEN_BITS-1:0] dn  [NS];
  logic                ovf [NS];
  logic [DEN_BITS-1:0] rem_n [NS];
  logic                ge_n  [NS];

  always_comb begin
    logic [DEN_BITS:0] r2;
    rem_n[0] = '0;
    ge_n[0] = 1'b0;
    for (int k = 1; k < NS; k++) begin
      r2 = {rem[k-1], low[k-1][Q_BITS-1]};
      ge_n[k] = (r2 >= {1'b0, dn[k-1]});
      rem_n[k] = ge_n[k] ? 16'(r2 - {1'b0, dn[k-1]}) : r2[DEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, num[NUM_BITS-1:Q_BITS]};
      low[0] <= num[Q_BITS-1:0];
      q[0] <= '0;
      dn[0] <= den;
      ovf[0] <= ({1'b0, num[NUM_BITS-1:Q_BITS]} >= den);
      for (int k = 1; k < NS; k++) begin
        rem[k] <= rem_n[k];
        low[k] <= {low[k-1][Q_BITS-2:0], 1'b0};
        q[k] <= {q[k-1][Q_BITS-2:0], ge_n[k]};
        dn[k] <= dn[k-1];
        ovf[k] <= ovf[k-1];
      end
      quot <= (ovf[NS-1] || (q[NS-1] > ONE_Q)) ? ONE_Q : q[NS-1];
    end
  end
endmodule

// ----- sv/stick_dead_zone_shaper.sv -----
// Top level of the stick dead-zone shaper.
// Usage:
// - s_axis carries one stick sample per word; m_axis returns one shaped word per
//   sample, in order. cfg_we/cfg_index/cfg_data write zone_mode (0), dead_zone (1)
//   and full_scale (2); write them only while no sample is in flight.
// - Throughput is one sample per cycle unless m_axis stalls: every stage is
//   registered, the square root and the three dividers resolve one bit per stage.
// - Circular mode: square, root, dead-zone divide, scale by the wanted length, then
//   divide per axis. Independent and no-zone modes use only the per-axis dividers.
// - When m_axis_tready is low with a word waiting, the whole pipeline holds and
//   s_axis_tready drops in the same cycle; nothing is lost or repeated.
// - Reset clears the valid bits and restores zone_mode 0, dead_zone 7849 and
//   full_scale 32767.
// - A dead zone not below full scale returns zero axes with bad_config set.
module stick_dead_zone_shaper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sdz_pkg::IN_BITS-1:0]       s_axis_tdata,  // axis_x, axis_y
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sdz_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,  // shaped_x, shaped_y
  output logic                              m_axis_tuser,  // bad_config
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [sdz_pkg::REG_BITS-1:0]      cfg_data
);
  import sdz_pkg::*;

  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
  } sb1_t;

  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [ROOT_BITS-1:0]   len;
  } sb2_t;

  typedef struct packed {
    logic valid;
    logic negx;
    logic negy;
    logic zero;
    logic bad;
  } sb3_t;

  logic                en;
  logic [1:0]          zone_mode;
  logic [REG_BITS-1:0] dead_zone;
  logic [REG_BITS-1:0] full_scale;
  logic [REG_BITS-1:0] zone;
  logic                circ;
  logic                bad;
  logic [DEN_BITS-1:0] span;

  logic                      va;
  logic signed [SAMPLE_BITS-1:0] xa, ya;
  logic signed [SQ_BITS-1:0] xa_w, ya_w;
  logic                      vb;
  logic [SAMPLE_BITS-1:0]    xb, yb;
  logic [SQ_BITS-1:0]        xxb, yyb;
  logic [ROOT_BITS-1:0]      len;
  sb1_t                      sb1 [SQRT_LAT];
  logic                      vd;
  logic [SAMPLE_BITS-1:0]    xd, yd;
  logic [ROOT_BITS-1:0]      lend;
  logic [NUM_BITS-1:0]       numd;
  logic [Q_BITS-1:0]         wanted;
  sb2_t                      sb2 [DIV_LAT];
  sb2_t                      s2;
  logic [16:0]               ax, ay, dx, dy;
  logic [32:0]               px, py;
  logic                      ve;
  logic [NUM_BITS-1:0]       numxe, numye;
  logic [DEN_BITS-1:0]       dene;
  logic                      negxe, negye, zeroe, bade;
  logic [Q_BITS-1:0]         qx, qy;
  sb3_t                      sb3 [DIV_LAT];
  sb3_t                      s3;
  logic [OUT_BITS-1:0]       rx, ry;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_mode <= MODE_INDEP;
      dead_zone <= RST_DEAD_ZONE;
      full_scale <= RST_FULL_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZONE_MODE:  zone_mode <= cfg_data[1:0];
        REG_DEAD_ZONE:  dead_zone <= cfg_data;
        REG_FULL_SCALE: full_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign zone = (zone_mode == MODE_INDEP || zone_mode == MODE_CIRC) ? dead_zone : '0;
  assign circ = (zone_mode == MODE_CIRC);
  assign bad = (zone >= full_scale);
  assign span = {1'b0, 15'(full_scale - zone)};

  assign xa_w = {{(SQ_BITS-SAMPLE_BITS){xa[SAMPLE_BITS-1]}}, xa};
  assign ya_w = {{(SQ_BITS-SAMPLE_BITS){ya[SAMPLE_BITS-1]}}, ya};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < SQRT_LAT; k++) sb1[k] <= '0;
      for (int k = 0; k < DIV_LAT; k++) begin
        sb2[k] <= '0;
        sb3[k] <= '0;
      end
    end else if (en) begin
      va <= s_axis_tvalid;
      vb <= va;
      sb1[0] <= '{valid: vb, x: xb, y: yb};
      for (int k = 1; k < SQRT_LAT; k++) sb1[k] <= sb1[k-1];
      vd <= sb1[SQRT_LAT-1].valid;
      sb2[0] <= '{valid: vd, x: xd, y: yd, len: lend};
      for (int k = 1; k < DIV_LAT; k++) sb2[k] <= sb2[k-1];
      ve <= s2.valid;
      sb3[0] <= '{valid: ve, negx: negxe, negy: negye, zero: zeroe, bad: bade};
      for (int k = 1; k < DIV_LAT; k++) sb3[k] <= sb3[k-1];
      m_axis_tvalid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= s_axis_tdata[SAMPLE_BITS-1:0];
      ya <= s_axis_tdata[IN_BITS-1:SAMPLE_BITS];
      xb <= xa;
      yb <= ya;
      xxb <= xa_w * xa_w;
      yyb <= ya_w * ya_w;
    end
  end

  sdz_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (xxb + yyb),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      xd <= sb1[SQRT_LAT-1].x;
      yd <= sb1[SQRT_LAT-1].y;
      lend <= len;
      numd <= (len > {1'b0, zone}) ? {16'(len - {1'b0, zone}), 15'd0} : '0;
    end
  end

  sdz_div u_div_len (
    .clk  (clk),
    .en   (en),
    .num  (numd),
    .den  (span),
    .quot (wanted)
  );

  assign s2 = sb2[DIV_LAT-1];
  assign ax = s2.x[SAMPLE_BITS-1] ? (17'd0 - {s2.x[SAMPLE_BITS-1], s2.x}) : {1'b0, s2.x};
  assign ay = s2.y[SAMPLE_BITS-1] ? (17'd0 - {s2.y[SAMPLE_BITS-1], s2.y}) : {1'b0, s2.y};
  assign dx = ax - {2'b00, zone};
  assign dy = ay - {2'b00, zone};
  assign px = ax * wanted;
  assign py = ay * wanted;

  always_ff @(posedge clk) begin
    if (en) begin
      if (circ) begin
        numxe <= px[NUM_BITS-1:0];
        numye <= py[NUM_BITS-1:0];
        dene <= s2.len;
      end else begin
        numxe <= (ax > {2'b00, zone}) ? {dx[15:0], 15'd0} : '0;
        numye <= (ay > {2'b00, zone}) ? {dy[15:0], 15'd0} : '0;
        dene <= span;
      end
      negxe <= s2.x[SAMPLE_BITS-1];
      negye <= s2.y[SAMPLE_BITS-1];
      zeroe <= circ && (wanted == '0);
      bade <= bad;
    end
  end

  sdz_div u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (numxe),
    .den  (dene),
    .quot (qx)
  );

  sdz_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (numye),
    .den  (dene),
    .quot (qy)
  );

  assign s3 = sb3[DIV_LAT-1];
  assign rx = (s3.zero || s3.bad) ? '0 :
              (s3.negx ? (17'd0 - {1'b0, qx}) : {1'b0, qx});
  assign ry = (s3.zero || s3.bad) ? '0 :
              (s3.negy ? (17'd0 - {1'b0, qy}) : {1'b0, qy});

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {6'd0, ry, rx};
      m_axis_tuser <= s3.bad;
    end
  end

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[33:0] == '0)
    else $error("bad_config word carries nonzero axes");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[16:0]) <= 17'sd32768) &&
                      ($signed(m_axis_tdata[16:0]) >= -17'sd32768) &&
                      ($signed(m_axis_tdata[33:17]) <= 17'sd32768) &&
                      ($signed(m_axis_tdata[33:17]) >= -17'sd32768))
    else $error("shaped axis outside plus or minus 1.0");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
`endif
endmodule

// ----- sim/stick_dead_zone_shaper_test.sv -----
// Self-checking testbench for the stick dead-zone shaper.
`timescale 1ns / 1ps

module stick_dead_zone_shaper_test;
  import sdz_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_BITS-1:0] s_axis_tdata = '0;        // axis_x, axis_y
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;       // shaped_x, shaped_y
  logic m_axis_tuser;                           // bad_config
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_ZONE_MODE;
  logic [REG_BITS-1:0] cfg_data = '0;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] sx;
    logic signed [OUT_BITS-1:0] sy;
    logic bad;
  } shaped_t;

  logic [1:0] mode_q;
  logic [REG_BITS-1:0] zone_q;
  logic [REG_BITS-1:0] fs_q;

  logic [IN_BITS-1:0] pending_samples[$];
  shaped_t expected_shapes[$];
  int fails = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_off = 0;

  stick_dead_zone_shaper dut (.*);

  always #5 clk = ~clk;

  function automatic longint quot_sat(longint num, longint den);
    longint q;
    q = num / den;
    return (q > 32768) ? 32768 : q;
  endfunction

  function automatic longint dead_zone_map(longint v, longint zone, longint fs);
    if (v > zone) return quot_sat((v - zone) << FRAC_BITS, fs - zone);
    if (v < -zone) return -quot_sat((-v - zone) << FRAC_BITS, fs - zone);
    return 0;
  endfunction

  function automatic longint int_root(longint n);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= n) r = r + (64'd1 << b);
    end
    return r;
  endfunction

  function automatic shaped_t shape_sample(logic [IN_BITS-1:0] d);
    shaped_t r;
    longint x, y, zone, fs, len, want, mx, my;
    x = longint'($signed(d[SAMPLE_BITS-1:0]));
    y = longint'($signed(d[IN_BITS-1:SAMPLE_BITS]));
    zone = (mode_q == MODE_INDEP || mode_q == MODE_CIRC) ? longint'(zone_q) : 0;
    fs = longint'(fs_q);
    r = '0;
    if (zone >= fs) begin
      r.bad = 1'b1;
    end else if (mode_q == MODE_CIRC) begin
      len = int_root(x * x + y * y);
      want = dead_zone_map(len, zone, fs);
      if (want > 0) begin
        mx = quot_sat((x < 0 ? -x : x) * want, len);
        my = quot_sat((y < 0 ? -y : y) * want, len);
        r.sx = OUT_BITS'(x < 0 ? -mx : mx);
        r.sy = OUT_BITS'(y < 0 ? -my : my);
      end
    end else begin
      r.sx = OUT_BITS'(dead_zone_map(x, zone, fs));
      r.sy = OUT_BITS'(dead_zone_map(y, zone, fs));
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_shapes.push_back(shape_sample(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_samples.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_samples.pop_front();
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    shaped_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{sx: m_axis_tdata[OUT_BITS-1:0], sy: m_axis_tdata[2*OUT_BITS-1:OUT_BITS],
                bad: m_axis_tuser};
        if (expected_shapes.size() == 0) begin
          $error("unexpected word %h", m_axis_tdata);
          fails++;
        end else begin
          want = expected_shapes.pop_front();
          if (got.sx !== want.sx) begin
            $error("shaped_x expected %0d got %0d", want.sx, got.sx);
            fails++;
          end
          if (got.sy !== want.sy) begin
            $error("shaped_y expected %0d got %0d", want.sy, got.sy);
            fails++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_config expected %0d got %0d", want.bad, got.bad);
            fails++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!m_axis_tready || m_axis_tvalid) begin
        m_axis_tready <= 1'b1;
        stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [REG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ZONE_MODE: mode_q = val[1:0];
      REG_DEAD_ZONE: zone_q = val;
      default: fs_q = val;
    endcase
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !s_axis_tvalid);
    wait (expected_shapes.size() == 0);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [IN_BITS-1:0] pack_xy(int x, int y);
    return {y[SAMPLE_BITS-1:0], x[SAMPLE_BITS-1:0]};
  endfunction

  task automatic load_random(int n);
    int x, y, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 3);
      x = (r == 0) ? $urandom_range(0, 20000) - 10000 : $urandom_range(0, 65535) - 32768;
      y = (r == 1) ? $urandom_range(0, 20000) - 10000 : $urandom_range(0, 65535) - 32768;
      pending_samples.push_back(pack_xy(x, y));
    end
  endtask

  initial begin
    int edge_vals[6];
    mode_q = MODE_INDEP;
    zone_q = RST_DEAD_ZONE;
    fs_q = RST_FULL_SCALE;
    edge_vals = '{-32768, 32767, 0, 7849, -7850, 1};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (edge_vals[i]) pending_samples.push_back(pack_xy(edge_vals[i], edge_vals[5-i]));
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_ZONE_MODE, REG_BITS'(m));
      foreach (edge_vals[i]) pending_samples.push_back(pack_xy(edge_vals[i], edge_vals[i]));
      pending_samples.push_back(pack_xy(3, 4));
      drain();
    end
    // bad configs and extremes
    write_reg(REG_ZONE_MODE, REG_BITS'(MODE_INDEP));
    write_reg(REG_DEAD_ZONE, 15'd100);
    write_reg(REG_FULL_SCALE, 15'd100);
    load_random(4);
    drain();
    write_reg(REG_ZONE_MODE, REG_BITS'(MODE_NONE));
    write_reg(REG_FULL_SCALE, 15'd0);
    load_random(4);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_ZONE_MODE, REG_BITS'($urandom_range(0, 3)));
      write_reg(REG_DEAD_ZONE, (ph == 0) ? 15'd0 : (ph == 1) ? 15'd32766 :
                REG_BITS'($urandom_range(0, 20000)));
      write_reg(REG_FULL_SCALE, (ph == 0) ? 15'd1 : (ph == 1) ? 15'd32767 :
                REG_BITS'($urandom_range(1, 32767)));
      if (ph == 4) hold_off = 300;
      load_random(100);
      drain();
    end
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- stick_dead_zone_shaper.f -----
sv/sdz_pkg.sv
sv/sdz_sqrt.sv
sv/sdz_div.sv
sv/stick_dead_zone_shaper.sv
sim/stick_dead_zone_shaper_test.sv
